/* design/mncg_pkg.sv */
// mncg_pkg: types, register indexes, send modes and status codes shared by the
// midi note/cc message generator. No dependencies.
package mncg_pkg;

    localparam int unsigned CfgAddrW = 4;
    localparam int unsigned CfgDataW = 32;

    localparam logic [1:0] RegSendMode     = 2'd0;
    localparam logic [1:0] RegMidiChannel  = 2'd1;
    localparam logic [1:0] RegNoteDuration = 2'd2;

    localparam logic [2:0] ModeFixed = 3'd0;
    localparam logic [2:0] ModeGate  = 3'd1;
    localparam logic [2:0] ModeCc    = 3'd2;
    localparam logic [2:0] ModeStart = 3'd3;
    localparam logic [2:0] ModeStop  = 3'd4;
    localparam logic [2:0] ModeCont  = 3'd5;

    localparam logic [7:0] StatusNoteOn = 8'h90;
    localparam logic [7:0] StatusCc     = 8'hB0;
    localparam logic [7:0] StatusStart  = 8'hFA;
    localparam logic [7:0] StatusStop   = 8'hFC;
    localparam logic [7:0] StatusCont   = 8'hFB;

    localparam logic [1:0] CountChannel  = 2'd3;
    localparam logic [1:0] CountRealtime = 2'd1;

    localparam logic [6:0]  VelMax  = 7'd127;
    localparam logic [16:0] FracOne = 17'h10000;
    localparam logic [16:0] DurMin  = 17'd1;
    localparam logic [16:0] DurMax  = 17'd100000;
    localparam logic [4:0]  ChanMin = 5'd1;
    localparam logic [4:0]  ChanMax = 5'd16;

    localparam logic [2:0]  RstSendMode     = ModeFixed;
    localparam logic [4:0]  RstMidiChannel  = 5'd1;
    localparam logic [16:0] RstNoteDuration = 17'd100;

    typedef struct packed {
        logic [2:0]  send_mode;
        logic [4:0]  midi_channel;
        logic [16:0] note_duration_ms;
    } t_cfg;

    typedef struct packed {
        logic              trigger_level;
        logic [6:0]        note_or_controller;
        logic [16:0]       velocity_fraction;
        logic signed [8:0] velocity_override;
        logic [31:0]       time_ms;
    } t_in_item;

    typedef struct packed {
        logic       message_valid;
        logic [7:0] status_byte;
        logic [6:0] data_one;
        logic [6:0] data_two;
        logic [1:0] byte_count;
        logic [6:0] echo_value;
    } t_out_item;

    typedef struct packed {
        logic        trigger_latch;
        logic        off_pending;
        logic [6:0]  off_note;
        logic [7:0]  off_status;
        logic [31:0] note_on_time;
    } t_state;

endpackage

/* design/mncg_if.sv */
// mncg_in_if / mncg_out_if: valid/ready channels for input ticks and messages.
// Depends on nothing.
interface mncg_in_if;
    logic              valid;
    logic              ready;
    logic              trigger_level;
    logic [6:0]        note_or_controller;
    logic [16:0]       velocity_fraction;
    logic signed [8:0] velocity_override;
    logic [31:0]       time_ms;

    modport source (output valid, trigger_level, note_or_controller, velocity_fraction,
                    velocity_override, time_ms, input ready);
    modport sink (input valid, trigger_level, note_or_controller, velocity_fraction,
                  velocity_override, time_ms, output ready);
endinterface

interface mncg_out_if;
    logic       valid;
    logic       ready;
    logic       message_valid;
    logic [7:0] status_byte;
    logic [6:0] data_one;
    logic [6:0] data_two;
    logic [1:0] byte_count;
    logic [6:0] echo_value;

    modport source (output valid, message_valid, status_byte, data_one, data_two,
                    byte_count, echo_value, input ready);
    modport sink (input valid, message_valid, status_byte, data_one, data_two,
                  byte_count, echo_value, output ready);
endinterface

/* design/mncg_cfg.sv */
// mncg_cfg: apb-style register file for send mode, channel and note duration.
// Depends on mncg_pkg.
module mncg_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mncg_pkg::CfgAddrW-1:0] paddr,
    input  logic [mncg_pkg::CfgDataW-1:0] pwdata,
    output logic [mncg_pkg::CfgDataW-1:0] prdata,
    output logic                          pready,
    output mncg_pkg::t_cfg                o_cfg
);
    mncg_pkg::t_cfg r_cfg;
    logic           wr_en;
    logic [1:0]     reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.send_mode        <= mncg_pkg::RstSendMode;
            r_cfg.midi_channel     <= mncg_pkg::RstMidiChannel;
            r_cfg.note_duration_ms <= mncg_pkg::RstNoteDuration;
        end else if (wr_en) begin
            unique case (reg_idx)
                mncg_pkg::RegSendMode:     r_cfg.send_mode        <= pwdata[2:0];
                mncg_pkg::RegMidiChannel:  r_cfg.midi_channel     <= pwdata[4:0];
                mncg_pkg::RegNoteDuration: r_cfg.note_duration_ms <= pwdata[16:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            mncg_pkg::RegSendMode:     prdata = {29'd0, r_cfg.send_mode};
            mncg_pkg::RegMidiChannel:  prdata = {27'd0, r_cfg.midi_channel};
            mncg_pkg::RegNoteDuration: prdata = {15'd0, r_cfg.note_duration_ms};
            default:                   prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;
endmodule

/* design/mncg_msg.sv */
// mncg_msg: edge detect, velocity scaling, duration check and message build for one tick,
// plus the next value of the generator state. Depends on mncg_pkg.
module mncg_msg (
    input  mncg_pkg::t_in_item  i_item,
    input  mncg_pkg::t_cfg      i_cfg,
    input  mncg_pkg::t_state    i_state,
    output mncg_pkg::t_out_item o_result,
    output mncg_pkg::t_state    o_state
);
    logic [4:0]  chan;
    logic [3:0]  chan_nib;
    logic [16:0] dur;
    logic [16:0] frac;
    logic [23:0] prod;
    logic [6:0]  vel;
    logic        rise;
    logic        fall;
    logic [31:0] elapsed;
    logic        expired;
    logic [7:0]  st_on;
    logic [7:0]  st_cc;

    always_comb begin
        if (i_cfg.midi_channel < mncg_pkg::ChanMin) begin
            chan = mncg_pkg::ChanMin;
        end else if (i_cfg.midi_channel > mncg_pkg::ChanMax) begin
            chan = mncg_pkg::ChanMax;
        end else begin
            chan = i_cfg.midi_channel;
        end
        chan_nib = 4'(chan - 5'd1);

        if (i_cfg.note_duration_ms < mncg_pkg::DurMin) begin
            dur = mncg_pkg::DurMin;
        end else if (i_cfg.note_duration_ms > mncg_pkg::DurMax) begin
            dur = mncg_pkg::DurMax;
        end else begin
            dur = i_cfg.note_duration_ms;
        end

        // fraction times 127 as shift and subtract
        frac = (i_item.velocity_fraction > mncg_pkg::FracOne) ? mncg_pkg::FracOne
                                                              : i_item.velocity_fraction;
        prod = {frac, 7'd0} - {7'd0, frac};
        if (i_item.velocity_override[8]) begin
            vel = prod[22:16];
        end else if (i_item.velocity_override[7:0] > {1'b0, mncg_pkg::VelMax}) begin
            vel = mncg_pkg::VelMax;
        end else begin
            vel = i_item.velocity_override[6:0];
        end

        rise    = i_item.trigger_level && !i_state.trigger_latch;
        fall    = !i_item.trigger_level && i_state.trigger_latch;
        elapsed = i_item.time_ms - i_state.note_on_time;
        expired = elapsed > {15'd0, dur};
        st_on   = mncg_pkg::StatusNoteOn | {4'd0, chan_nib};
        st_cc   = mncg_pkg::StatusCc | {4'd0, chan_nib};

        o_result = '0;
        o_state  = i_state;
        o_state.trigger_latch = i_item.trigger_level;

        unique case (i_cfg.send_mode)
            mncg_pkg::ModeFixed: begin
                if (rise) begin
                    o_result = '{1'b1, st_on, i_item.note_or_controller, vel,
                                 mncg_pkg::CountChannel, vel};
                    o_state.note_on_time = i_item.time_ms;
                    o_state.off_note     = i_item.note_or_controller;
                    o_state.off_status   = st_on;
                    o_state.off_pending  = 1'b1;
                end else if (i_state.off_pending && expired) begin
                    o_result = '{1'b1, i_state.off_status, i_state.off_note, 7'd0,
                                 mncg_pkg::CountChannel, 7'd0};
                    o_state.off_pending = 1'b0;
                end
            end
            mncg_pkg::ModeGate: begin
                if (rise) begin
                    o_result = '{1'b1, st_on, i_item.note_or_controller, vel,
                                 mncg_pkg::CountChannel, vel};
                end else if (fall) begin
                    o_result = '{1'b1, st_on, i_item.note_or_controller, 7'd0,
                                 mncg_pkg::CountChannel, 7'd0};
                end
            end
            mncg_pkg::ModeCc: begin
                o_result = '{1'b1, st_cc, i_item.note_or_controller, vel,
                             mncg_pkg::CountChannel, vel};
            end
            mncg_pkg::ModeStart: begin
                o_result = '{1'b1, mncg_pkg::StatusStart, 7'd0, 7'd0,
                             mncg_pkg::CountRealtime, 7'd0};
            end
            mncg_pkg::ModeStop: begin
                o_result = '{1'b1, mncg_pkg::StatusStop, 7'd0, 7'd0,
                             mncg_pkg::CountRealtime, 7'd0};
            end
            mncg_pkg::ModeCont: begin
                o_result = '{1'b1, mncg_pkg::StatusCont, 7'd0, 7'd0,
                             mncg_pkg::CountRealtime, 7'd0};
            end
            default: ;
        endcase
    end
endmodule

/* design/mncg_pipe.sv */
// mncg_pipe: input register, generator state and result register around mncg_msg.
// Depends on mncg_pkg and mncg_msg.
module mncg_pipe (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  mncg_pkg::t_in_item  i_in_item,
    input  mncg_pkg::t_cfg      i_cfg,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output mncg_pkg::t_out_item o_out_item
);
    logic                r_s1_vld;
    mncg_pkg::t_in_item  r_s1_item;
    logic                r_out_vld;
    mncg_pkg::t_out_item r_out_item;
    mncg_pkg::t_state    r_state;
    mncg_pkg::t_state    n_state;
    mncg_pkg::t_out_item n_out_item;
    logic                adv;
    logic                fire;

    assign adv        = !r_out_vld || i_out_ready;
    assign fire       = r_s1_vld && adv;
    assign o_in_ready = !r_s1_vld || adv;

    mncg_msg u_msg (
        .i_item   (r_s1_item),
        .i_cfg    (i_cfg),
        .i_state  (r_state),
        .o_result (n_out_item),
        .o_state  (n_state)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_state   <= '0;
        end else begin
            if (o_in_ready) begin
                r_s1_vld <= i_in_valid;
            end
            if (adv) begin
                r_out_vld <= r_s1_vld;
            end
            if (fire) begin
                r_state <= n_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_s1_item <= i_in_item;
        end
        if (fire) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out_item;

`ifndef SYNTH
    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_s1_vld && r_out_vld && !i_out_ready))
        else $error("input stalled while the pipeline can move");

    a_fire_fills_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> r_out_vld)
        else $error("processed beat did not reach the result register");

    a_latch_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> (r_state.trigger_latch == $past(r_s1_item.trigger_level)))
        else $error("trigger latch did not follow the processed level");

    a_note_on_arms_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && i_cfg.send_mode == mncg_pkg::ModeFixed && r_s1_item.trigger_level
         && !r_state.trigger_latch) |=> r_state.off_pending)
        else $error("fixed note-on did not arm the note-off");

    a_state_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!fire && $past(i_rst_n)) |=> $stable(r_state))
        else $error("state changed without a processed beat");
`endif
endmodule

/* design/midi_note_cc_message_generator_top.sv */
// midi_note_cc_message_generator_top: apb register file plus the tick pipeline.
// Depends on mncg_pkg, mncg_if, mncg_cfg, mncg_msg and mncg_pipe.
//
//  channel | port          | direction | carries
//  --------+---------------+-----------+-------------------------------------------
//  ticks   | i_in          | sink      | trigger, note/controller, velocity, time
//  results | o_out         | source    | one midi message (or none) per tick beat
//  config  | psel..prdata  | slave     | send_mode, midi_channel, note_duration_ms
//
// one tick beat per cycle while the result is not stalled; input register then result register
// the state update and message build sit in one combinational pass between them
// synchronous active-low reset clears the state, the registers go to their defaults
// a stalled result holds the pipeline; ready drops only when both stages are full
module midi_note_cc_message_generator_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    mncg_in_if.sink                       i_in,
    mncg_out_if.source                    o_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mncg_pkg::CfgAddrW-1:0] paddr,
    input  logic [mncg_pkg::CfgDataW-1:0] pwdata,
    output logic [mncg_pkg::CfgDataW-1:0] prdata,
    output logic                          pready
);
    mncg_pkg::t_cfg      cfg;
    mncg_pkg::t_in_item  in_item;
    mncg_pkg::t_out_item out_item;
    logic                in_ready;
    logic                out_valid;

    mncg_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    assign in_item.trigger_level      = i_in.trigger_level;
    assign in_item.note_or_controller = i_in.note_or_controller;
    assign in_item.velocity_fraction  = i_in.velocity_fraction;
    assign in_item.velocity_override  = i_in.velocity_override;
    assign in_item.time_ms            = i_in.time_ms;
    assign i_in.ready                 = in_ready;

    mncg_pipe u_pipe (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .i_cfg       (cfg),
        .o_out_valid (out_valid),
        .i_out_ready (o_out.ready),
        .o_out_item  (out_item)
    );

    assign o_out.valid         = out_valid;
    assign o_out.message_valid = out_item.message_valid;
    assign o_out.status_byte   = out_item.status_byte;
    assign o_out.data_one      = out_item.data_one;
    assign o_out.data_two      = out_item.data_two;
    assign o_out.byte_count    = out_item.byte_count;
    assign o_out.echo_value    = out_item.echo_value;
endmodule

/* dv/midi_note_cc_message_generator_top_test.sv */
`timescale 1ns / 1ps
// Self-checking bench for midi_note_cc_message_generator_top: apb setup, directed
// ticks per mode, then random ticks checked against an in-bench message predictor.
// Depends on mncg_pkg, mncg_if and the top-level rtl.
module midi_note_cc_message_generator_top_test;

    localparam logic [1:0] RegUnused = 2'd3;
    localparam logic [2:0] ModeQuiet6 = 3'd6;
    localparam logic [2:0] ModeQuiet7 = 3'd7;
    localparam int unsigned TickTarget = 1900;
    localparam int unsigned CalmTail = 300;
    localparam int unsigned ReportCap = 40;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [mncg_pkg::CfgAddrW-1:0] paddr;
    logic [mncg_pkg::CfgDataW-1:0] pwdata;
    logic [mncg_pkg::CfgDataW-1:0] prdata;
    logic                          pready;

    mncg_in_if  tick_if ();
    mncg_out_if msg_if ();

    mncg_pkg::t_cfg      cfg_shadow;
    mncg_pkg::t_state    gen_state;
    mncg_pkg::t_out_item expected_msgs[$];
    int unsigned         mismatches;
    bit                  calm;

    always #6 i_clk = ~i_clk;

    midi_note_cc_message_generator_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (tick_if),
        .o_out   (msg_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    function automatic void predict_message(input mncg_pkg::t_in_item it);
        logic [4:0]          chan;
        logic [16:0]         dur;
        logic [16:0]         frac;
        logic [23:0]         scaled;
        logic [31:0]         elapsed;
        logic [6:0]          vel;
        logic [7:0]          note_st;
        logic [7:0]          cc_st;
        logic                rise;
        logic                fall;
        mncg_pkg::t_out_item msg;

        chan = cfg_shadow.midi_channel;
        if (chan < mncg_pkg::ChanMin) chan = mncg_pkg::ChanMin;
        if (chan > mncg_pkg::ChanMax) chan = mncg_pkg::ChanMax;
        dur = cfg_shadow.note_duration_ms;
        if (dur < mncg_pkg::DurMin) dur = mncg_pkg::DurMin;
        if (dur > mncg_pkg::DurMax) dur = mncg_pkg::DurMax;
        note_st = mncg_pkg::StatusNoteOn | {4'h0, 4'(chan - 5'd1)};
        cc_st = mncg_pkg::StatusCc | {4'h0, 4'(chan - 5'd1)};

        // negative override selects the q1.16 fraction
        if (it.velocity_override[8]) begin
            frac = (it.velocity_fraction > mncg_pkg::FracOne) ? mncg_pkg::FracOne
                                                              : it.velocity_fraction;
            scaled = 24'(frac) * 24'(mncg_pkg::VelMax);
            vel = scaled[22:16];
        end else begin
            vel = (it.velocity_override[7:0] > {1'b0, mncg_pkg::VelMax}) ? mncg_pkg::VelMax
                                                                          : it.velocity_override[6:0];
        end

        rise = it.trigger_level && !gen_state.trigger_latch;
        fall = !it.trigger_level && gen_state.trigger_latch;
        gen_state.trigger_latch = it.trigger_level;
        elapsed = it.time_ms - gen_state.note_on_time;

        msg = '0;
        case (cfg_shadow.send_mode)
            mncg_pkg::ModeFixed: begin
                if (rise) begin
                    msg = '{1'b1, note_st, it.note_or_controller, vel,
                            mncg_pkg::CountChannel, vel};
                    gen_state.note_on_time = it.time_ms;
                    gen_state.off_note = it.note_or_controller;
                    gen_state.off_status = note_st;
                    gen_state.off_pending = 1'b1;
                end else if (gen_state.off_pending && elapsed > {15'd0, dur}) begin
                    msg = '{1'b1, gen_state.off_status, gen_state.off_note, 7'd0,
                            mncg_pkg::CountChannel, 7'd0};
                    gen_state.off_pending = 1'b0;
                end
            end
            mncg_pkg::ModeGate: begin
                if (rise) begin
                    msg = '{1'b1, note_st, it.note_or_controller, vel,
                            mncg_pkg::CountChannel, vel};
                end else if (fall) begin
                    msg = '{1'b1, note_st, it.note_or_controller, 7'd0,
                            mncg_pkg::CountChannel, 7'd0};
                end
            end
            mncg_pkg::ModeCc: msg = '{1'b1, cc_st, it.note_or_controller, vel,
                                      mncg_pkg::CountChannel, vel};
            mncg_pkg::ModeStart: msg = '{1'b1, mncg_pkg::StatusStart, 7'd0, 7'd0,
                                         mncg_pkg::CountRealtime, 7'd0};
            mncg_pkg::ModeStop: msg = '{1'b1, mncg_pkg::StatusStop, 7'd0, 7'd0,
                                        mncg_pkg::CountRealtime, 7'd0};
            mncg_pkg::ModeCont: msg = '{1'b1, mncg_pkg::StatusCont, 7'd0, 7'd0,
                                        mncg_pkg::CountRealtime, 7'd0};
            default: ;
        endcase
        expected_msgs.insert(expected_msgs.size(), msg);
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        mismatches++;
        if (mismatches <= ReportCap) begin
            $display("%0t: %s expected 0x%0h got 0x%0h", $time, what, want, got);
        end
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            mncg_pkg::RegSendMode: cfg_shadow.send_mode = val[2:0];
            mncg_pkg::RegMidiChannel: cfg_shadow.midi_channel = val[4:0];
            mncg_pkg::RegNoteDuration: cfg_shadow.note_duration_ms = val[16:0];
            default: ;
        endcase
    endtask

    task automatic send_tick(input logic lvl, input logic [6:0] note, input logic [16:0] frac,
                             input logic signed [8:0] ovr, input logic [31:0] tms);
        mncg_pkg::t_in_item it;

        it = '{lvl, note, frac, ovr, tms};
        if (!calm && $urandom_range(0, 4) == 0) begin
            tick_if.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        tick_if.valid <= 1'b1;
        tick_if.trigger_level <= it.trigger_level;
        tick_if.note_or_controller <= it.note_or_controller;
        tick_if.velocity_fraction <= it.velocity_fraction;
        tick_if.velocity_override <= it.velocity_override;
        tick_if.time_ms <= it.time_ms;
        do @(posedge i_clk); while (!tick_if.ready);
        predict_message(it);
    endtask

    task automatic drain_messages();
        tick_if.valid <= 1'b0;
        do @(posedge i_clk); while (expected_msgs.size() != 0);
    endtask

    // note-on, exact-duration hold, note-off across the 32-bit time wrap, retrigger
    task automatic test_fixed_duration();
        write_reg(mncg_pkg::RegSendMode, 32'(mncg_pkg::ModeFixed));
        write_reg(mncg_pkg::RegMidiChannel, 32'(mncg_pkg::ChanMax));
        write_reg(mncg_pkg::RegNoteDuration, 32'd100);
        send_tick(1'b1, 7'd127, 17'd0, 9'sd255, 32'hFFFF_FFC0);
        send_tick(1'b1, 7'd10, 17'd0, 9'sd127, 32'h0000_0024);
        send_tick(1'b0, 7'd10, 17'd0, 9'sd0, 32'h0000_0025);
        send_tick(1'b1, 7'd0, mncg_pkg::FracOne, -9'sd1, 32'h0000_1000);
        send_tick(1'b0, 7'd0, 17'h1FFFF, -9'sd1, 32'h0000_1005);
        send_tick(1'b1, 7'd5, 17'h1FFFF, -9'sd256, 32'h0000_1010);
        send_tick(1'b1, 7'd9, 17'h0FFFF, -9'sd1, 32'h0000_2000);
    endtask

    // gate edges, channel below range, junk upper data bits, unused register
    task automatic test_gate_edges();
        drain_messages();
        write_reg(mncg_pkg::RegSendMode, 32'hFFFF_FFF8 | 32'(mncg_pkg::ModeGate));
        write_reg(mncg_pkg::RegMidiChannel, 32'd0);
        write_reg(RegUnused, 32'hFFFF_FFFF);
        send_tick(1'b0, 7'd1, 17'd0, 9'sd0, 32'd0);
        send_tick(1'b1, 7'd64, 17'd0, -9'sd1, 32'd0);
        send_tick(1'b1, 7'd64, 17'd65535, -9'sd1, 32'd0);
        send_tick(1'b0, 7'd3, 17'd0, 9'sd0, 32'd0);
    endtask

    // a pending note-off survives a detour through gate mode
    task automatic test_pending_across_modes();
        drain_messages();
        write_reg(mncg_pkg::RegSendMode, 32'(mncg_pkg::ModeFixed));
        write_reg(mncg_pkg::RegNoteDuration, 32'd0);
        send_tick(1'b1, 7'd42, 17'd32768, -9'sd1, 32'd1000);
        drain_messages();
        write_reg(mncg_pkg::RegSendMode, 32'(mncg_pkg::ModeGate));
        send_tick(1'b0, 7'd7, 17'd0, 9'sd64, 32'd5000);
        drain_messages();
        write_reg(mncg_pkg::RegSendMode, 32'(mncg_pkg::ModeFixed));
        write_reg(mncg_pkg::RegMidiChannel, 32'd31);
        send_tick(1'b0, 7'd7, 17'd0, 9'sd64, 32'd5000);
        send_tick(1'b0, 7'd7, 17'd0, 9'sd64, 32'd9000);
    endtask

    task automatic test_stream_modes();
        logic [2:0] modes[6];

        modes = '{mncg_pkg::ModeCc, mncg_pkg::ModeStart, mncg_pkg::ModeStop,
                  mncg_pkg::ModeCont, ModeQuiet6, ModeQuiet7};
        foreach (modes[k]) begin
            drain_messages();
            write_reg(mncg_pkg::RegSendMode, 32'(modes[k]));
            send_tick(k[0], 7'd127, 17'd0, 9'sd255, 32'(k));
        end
        drain_messages();
        write_reg(mncg_pkg::RegSendMode, 32'(mncg_pkg::ModeCc));
        send_tick(1'b0, 7'd0, mncg_pkg::FracOne, -9'sd1, 32'd0);
    endtask

    // oversized duration saturates to the maximum
    task automatic test_duration_limits();
        drain_messages();
        write_reg(mncg_pkg::RegSendMode, 32'(mncg_pkg::ModeFixed));
        write_reg(mncg_pkg::RegNoteDuration, 32'h0001_FFFF);
        send_tick(1'b1, 7'd60, 17'd0, 9'sd90, 32'd0);
        send_tick(1'b1, 7'd60, 17'd0, 9'sd90, 32'(mncg_pkg::DurMax));
        send_tick(1'b0, 7'd60, 17'd0, 9'sd90, 32'(mncg_pkg::DurMax) + 32'd1);
    endtask

    task automatic test_random_traffic();
        int unsigned sent;
        int unsigned phase_len;
        int unsigned pick;
        logic [31:0] now;
        logic        lvl;
        logic [2:0]  mode;
        logic [4:0]  chan;
        logic [16:0] dur;
        logic [16:0] frac;
        logic [8:0]  ovr;

        sent = 0;
        now = $urandom;
        lvl = 1'b0;
        while (sent < TickTarget) begin
            drain_messages();
            pick = $urandom_range(0, 15);
            mode = (pick < 6) ? mncg_pkg::ModeFixed :
                   (pick < 10) ? mncg_pkg::ModeGate : 3'(pick - 8);
            case ($urandom_range(0, 9))
                0: chan = 5'd0;
                1: chan = 5'd31;
                2: chan = 5'($urandom_range(17, 30));
                default: chan = 5'($urandom_range(1, 16));
            endcase
            case ($urandom_range(0, 9))
                0: dur = 17'd0;
                1: dur = 17'h1FFFF;
                2: dur = mncg_pkg::DurMax;
                3: dur = 17'($urandom_range(1000, 99999));
                default: dur = 17'($urandom_range(1, 40));
            endcase
            write_reg(mncg_pkg::RegSendMode, 32'(mode));
            write_reg(mncg_pkg::RegMidiChannel, 32'(chan));
            write_reg(mncg_pkg::RegNoteDuration, 32'(dur));
            phase_len = $urandom_range(40, 160);
            calm = (sent + CalmTail >= TickTarget) || ($urandom_range(0, 3) == 0);
            repeat (phase_len) begin
                if ($urandom_range(0, 2) == 0) lvl = ~lvl;
                case ($urandom_range(0, 15))
                    0: now = $urandom;
                    1, 2, 3: now = now + $urandom_range(0, 150000);
                    default: now = now + $urandom_range(0, 60);
                endcase
                case ($urandom_range(0, 7))
                    0: frac = 17'($urandom_range(65537, 131071));
                    1: frac = mncg_pkg::FracOne;
                    2: frac = 17'd0;
                    default: frac = 17'($urandom_range(0, 65535));
                endcase
                case ($urandom_range(0, 3))
                    0: ovr = 9'($urandom_range(0, 127));
                    1: ovr = 9'($urandom_range(128, 255));
                    default: ovr = 9'($urandom_range(256, 511));
                endcase
                send_tick(lvl, 7'($urandom_range(0, 127)), frac, ovr, now);
                sent++;
            end
        end
    endtask

    initial begin : sink_drive
        msg_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (!calm && $urandom_range(0, 4) == 0) begin
                msg_if.ready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge i_clk);
            end
            msg_if.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : msg_check
        mncg_pkg::t_out_item want;

        if (i_rst_n && msg_if.valid && msg_if.ready) begin
            if (expected_msgs.size() == 0) begin
                report_mismatch("unexpected message beat", 32'd0, 32'd1);
            end else begin
                want = expected_msgs.pop_front();
                if (msg_if.message_valid !== want.message_valid)
                    report_mismatch("message_valid", 32'(want.message_valid),
                                    32'(msg_if.message_valid));
                if (msg_if.status_byte !== want.status_byte)
                    report_mismatch("status_byte", 32'(want.status_byte),
                                    32'(msg_if.status_byte));
                if (msg_if.data_one !== want.data_one)
                    report_mismatch("data_one", 32'(want.data_one), 32'(msg_if.data_one));
                if (msg_if.data_two !== want.data_two)
                    report_mismatch("data_two", 32'(want.data_two), 32'(msg_if.data_two));
                if (msg_if.byte_count !== want.byte_count)
                    report_mismatch("byte_count", 32'(want.byte_count),
                                    32'(msg_if.byte_count));
                if (msg_if.echo_value !== want.echo_value)
                    report_mismatch("echo_value", 32'(want.echo_value),
                                    32'(msg_if.echo_value));
            end
        end
    end

    initial begin : watchdog
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    initial begin : main_seq
        cfg_shadow = '{mncg_pkg::RstSendMode, mncg_pkg::RstMidiChannel,
                       mncg_pkg::RstNoteDuration};
        gen_state = '0;
        mismatches = 0;
        calm = 1'b0;
        i_rst_n <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        tick_if.valid <= 1'b0;
        tick_if.trigger_level <= 1'b0;
        tick_if.note_or_controller <= '0;
        tick_if.velocity_fraction <= '0;
        tick_if.velocity_override <= '0;
        tick_if.time_ms <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_fixed_duration();
        test_gate_edges();
        test_pending_across_modes();
        test_stream_modes();
        test_duration_limits();
        test_random_traffic();

        drain_messages();
        repeat (4) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

/* sim.f */
design/mncg_pkg.sv
design/mncg_if.sv
design/mncg_cfg.sv
design/mncg_msg.sv
design/mncg_pipe.sv
design/midi_note_cc_message_generator_top.sv
dv/midi_note_cc_message_generator_top_test.sv
